@@ hw/rtl/aabs_pkg.sv @@
// ----------------------------------------------------------------------------
// aabs_pkg
// Shared types and constants of the alpha-aware bilinear sampler.
// ----------------------------------------------------------------------------
package aabs_pkg;

  // Request opcodes.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_FRAME_COUNT  = 3'd2;
  localparam logic [2:0] REG_ACTIVE_FRAME = 3'd3;

  localparam logic [7:0]  ALPHA_LIMIT = 8'd128;
  localparam logic [23:0] HALF_Q16    = 24'd32768;
  localparam logic [16:0] ONE_Q16     = 17'h10000;

  // Stored pixel: transparent flag in bit 24, blue, green, red below.
  typedef logic [24:0] pixel_t;

  // One stage of the per-channel restoring divider.
  typedef struct packed {
    logic            rv;
    logic            tr;
    logic [34:0]     dv;
    logic [2:0][41:0] rem;
    logic [2:0][7:0]  q;
  } div_t;

endpackage

@@ hw/rtl/alpha_aware_bilinear_sampler.sv @@
// ----------------------------------------------------------------------------
// alpha_aware_bilinear_sampler
// Multi-frame RGB store with an alpha-aware bilinear sampling pipeline.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+-----------------------------------
//  in_      | input     | in_valid/in_ready  | opcode, write pixel, coord_u/v
//  out_     | output    | out_valid/out_ready| red, green, blue, transparent
//  cfg_     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One request enters per cycle while the output is not stalled. A sample
// request's result passes through four register stages for coordinate
// scaling, the banked store read, the weights and the color products, then
// eight divider stages of one quotient bit each, the first of which also forms
// the sums. Write requests leave no result.
// Reset is synchronous and active low; it clears the valid bits and the divider
// stages and sets the configuration registers to their defaults.
// A stalled output freezes the whole pipeline, so nothing is lost or repeated.

module alpha_aware_bilinear_sampler
  import aabs_pkg::*;
#(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128,
  parameter int MAX_FRAMES = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_opcode,
  input  logic [6:0]         in_write_x,
  input  logic [6:0]         in_write_y,
  input  logic [1:0]         in_write_frame,
  input  logic [7:0]         in_red_in,
  input  logic [7:0]         in_green_in,
  input  logic [7:0]         in_blue_in,
  input  logic [7:0]         in_alpha_in,
  input  logic signed [17:0] in_coord_u,
  input  logic signed [17:0] in_coord_v,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_red_out,
  output logic [7:0]         out_green_out,
  output logic [7:0]         out_blue_out,
  output logic               out_transparent_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [7:0]         cfg_data
);

  // The store is split into four banks by column and row parity, so the four
  // neighbours of any sample point lie in distinct banks (or share an entry
  // where clamping makes them equal). Only frames, rows and columns that the
  // write fields can reach are backed by storage.
  localparam int NF    = (MAX_FRAMES < 4) ? MAX_FRAMES : 4;
  localparam int NH    = (MAX_HEIGHT < 128) ? MAX_HEIGHT : 128;
  localparam int NW    = (MAX_WIDTH < 128) ? MAX_WIDTH : 128;
  localparam int HB    = (NH + 1) / 2;
  localparam int WB    = (NW + 1) / 2;
  localparam int DEPTH = NF * HB * WB;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NDIV  = 8;

  function automatic logic [AW-1:0] bank_addr(input logic [1:0] f, input logic [7:0] r,
                                               input logic [7:0] c);
    int a;
    a = (int'(f) * HB + int'(r[7:1])) * WB + int'(c[7:1]);
    return AW'(a);
  endfunction

  // Configuration registers. The user must change them only while the pipeline is empty; the block does not enforce it.
  logic [7:0] image_width_r, image_height_r;
  logic [2:0] frame_count_r;
  logic [1:0] active_frame_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= 8'd128;
      image_height_r <= 8'd128;
      frame_count_r  <= 3'd1;
      active_frame_r <= 2'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height_r <= cfg_data;
        REG_FRAME_COUNT:  frame_count_r  <= cfg_data[2:0];
        REG_ACTIVE_FRAME: active_frame_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together; the last divider stage is the output
  // register, so it advances whenever that register is empty or being taken.
  div_t dv_r [NDIV];
  logic adv;

  assign adv      = !dv_r[NDIV-1].rv || out_ready;
  assign in_ready = adv;

  // --------------------------------------------------------------------------
  // Stage A: range checks and scaling of the coordinates to pixel centers.
  // --------------------------------------------------------------------------
  logic        a_vld_r, a_smp_r, a_tr_r, a_wen_r;
  logic [23:0] a_px_r, a_py_r;
  logic [7:0]  a_w_r, a_h_r;
  logic [1:0]  a_frm_r, a_wf_r;
  logic [6:0]  a_wx_r, a_wy_r;
  pixel_t      a_wdata_r;

  logic [7:0]  w_eff, h_eff;
  logic        a_tr_nxt, a_wen_nxt;
  logic [23:0] a_px_nxt, a_py_nxt;

  always_comb begin
    w_eff = (32'(image_width_r) > MAX_WIDTH) ? 8'(MAX_WIDTH) : image_width_r;
    h_eff = (32'(image_height_r) > MAX_HEIGHT) ? 8'(MAX_HEIGHT) : image_height_r;
    // A coordinate with bit 17 (negative) or bit 16 (one or more) set falls
    // outside the unit square.
    a_tr_nxt = (in_coord_u[17:16] != 2'b00) || (in_coord_v[17:16] != 2'b00) ||
               ({1'b0, active_frame_r} >= frame_count_r) ||
               (32'(active_frame_r) >= MAX_FRAMES) ||
               (image_width_r == 8'd0) || (image_height_r == 8'd0);
    a_px_nxt = 24'(in_coord_u[15:0]) * 24'(w_eff) + HALF_Q16;
    a_py_nxt = 24'(in_coord_v[15:0]) * 24'(h_eff) + HALF_Q16;
    a_wen_nxt = (32'(in_write_x) < MAX_WIDTH) && (32'(in_write_y) < MAX_HEIGHT) &&
                (32'(in_write_frame) < MAX_FRAMES);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_smp_r   <= (in_opcode == OP_SAMPLE);
      a_tr_r    <= a_tr_nxt;
      a_px_r    <= a_px_nxt;
      a_py_r    <= a_py_nxt;
      a_w_r     <= w_eff;
      a_h_r     <= h_eff;
      a_frm_r   <= active_frame_r;
      a_wen_r   <= a_wen_nxt;
      a_wx_r    <= in_write_x;
      a_wy_r    <= in_write_y;
      a_wf_r    <= in_write_frame;
      a_wdata_r <= {in_alpha_in < ALPHA_LIMIT, in_blue_in, in_green_in, in_red_in};
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: neighbour indexes with edge clamping, and the banked store.
  // Writes and reads share this stage, so program order is kept.
  // --------------------------------------------------------------------------
  logic [7:0]    bx, by, xa, xb, ya, yb;
  logic [1:0][7:0] col_p, row_q;
  logic [AW-1:0] raddr [4];

  always_comb begin
    bx = a_px_r[23:16];
    by = a_py_r[23:16];
    xa = (bx == 8'd0) ? 8'd0 : ((bx - 8'd1 >= a_w_r) ? a_w_r - 8'd1 : bx - 8'd1);
    xb = (bx >= a_w_r) ? a_w_r - 8'd1 : bx;
    ya = (by == 8'd0) ? 8'd0 : ((by - 8'd1 >= a_h_r) ? a_h_r - 8'd1 : by - 8'd1);
    yb = (by >= a_h_r) ? a_h_r - 8'd1 : by;
    for (int p = 0; p < 2; p++) begin
      col_p[p] = (xa[0] == p[0]) ? xa : xb;
      row_q[p] = (ya[0] == p[0]) ? ya : yb;
    end
    for (int b = 0; b < 4; b++) begin
      raddr[b] = bank_addr(a_frm_r, row_q[b / 2], col_p[b % 2]);
    end
  end

  pixel_t        c_rd_r [4];
  logic [AW-1:0] waddr;
  logic          wr_go;

  assign waddr = bank_addr(a_wf_r, {1'b0, a_wy_r}, {1'b0, a_wx_r});
  assign wr_go = adv && a_vld_r && !a_smp_r && a_wen_r;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    pixel_t mem [DEPTH];

    always_ff @(posedge clk) begin
      if (wr_go && a_wy_r[0] == b[1] && a_wx_r[0] == b[0]) begin
        mem[waddr] <= a_wdata_r;
      end
      if (adv) begin
        c_rd_r[b] <= mem[raddr[b]];
      end
    end
  end

  logic        c_vld_r, c_tr_r;
  logic [15:0] c_fx_r, c_fy_r;
  logic [3:0]  c_sel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (adv) begin
      c_vld_r <= a_vld_r && a_smp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_tr_r  <= a_tr_r;
      c_fx_r  <= a_px_r[15:0];
      c_fy_r  <= a_py_r[15:0];
      c_sel_r <= {yb[0], xb[0], ya[0], xa[0]};
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: route bank outputs to the four neighbours, form the weights.
  // --------------------------------------------------------------------------
  pixel_t      c_px [4];
  logic [16:0] ix, iy;
  logic [33:0] c_wt [4];

  always_comb begin
    c_px[0] = c_rd_r[{c_sel_r[1], c_sel_r[0]}];
    c_px[1] = c_rd_r[{c_sel_r[1], c_sel_r[2]}];
    c_px[2] = c_rd_r[{c_sel_r[3], c_sel_r[0]}];
    c_px[3] = c_rd_r[{c_sel_r[3], c_sel_r[2]}];
    ix = ONE_Q16 - {1'b0, c_fx_r};
    iy = ONE_Q16 - {1'b0, c_fy_r};
    c_wt[0] = 34'(ix) * 34'(iy);
    c_wt[1] = 34'(c_fx_r) * 34'(iy);
    c_wt[2] = 34'(ix) * 34'(c_fy_r);
    c_wt[3] = 34'(c_fx_r) * 34'(c_fy_r);
  end

  logic        d_vld_r, d_tr_r;
  pixel_t      d_px_r [4];
  logic [32:0] d_wt_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (adv) begin
      d_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_tr_r <= c_tr_r;
      for (int k = 0; k < 4; k++) begin
        d_px_r[k] <= c_px[k];
        d_wt_r[k] <= c_wt[k][32:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage D: transparent neighbours drop out; weighted color products.
  // --------------------------------------------------------------------------
  logic [32:0] d_wm [4];
  logic [33:0] d_wsum;
  logic [40:0] d_prod [3][4];

  always_comb begin
    d_wsum = '0;
    for (int k = 0; k < 4; k++) begin
      d_wm[k] = d_px_r[k][24] ? 33'd0 : d_wt_r[k];
      d_wsum  = d_wsum + 34'(d_wm[k]);
      for (int c = 0; c < 3; c++) begin
        d_prod[c][k] = 41'(d_wm[k]) * 41'(d_px_r[k][8*c +: 8]);
      end
    end
  end

  logic        e_vld_r, e_tr_r;
  logic [33:0] e_wsum_r;
  logic [40:0] e_prod_r [3][4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else if (adv) begin
      e_vld_r <= d_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_tr_r   <= d_tr_r;
      e_wsum_r <= d_wsum;
      e_prod_r <= d_prod;
    end
  end

  // --------------------------------------------------------------------------
  // Stage E: sums and the divider operands. Each color is
  // floor((2*sum + wsum) / (2*wsum)), which rounds half up and never
  // exceeds 255. A zero weight sum means a transparent result.
  // --------------------------------------------------------------------------
  div_t        div_in;
  logic [42:0] e_num;

  always_comb begin
    div_in.rv = e_vld_r;
    div_in.tr = e_tr_r || (e_wsum_r == 34'd0);
    div_in.dv = {e_wsum_r, 1'b0};
    div_in.q  = '0;
    for (int c = 0; c < 3; c++) begin
      e_num = 43'(e_prod_r[c][0]) + 43'(e_prod_r[c][1]) +
              43'(e_prod_r[c][2]) + 43'(e_prod_r[c][3]);
      div_in.rem[c] = 42'({e_num[41:0], 1'b0} + 43'(e_wsum_r));
    end
  end

  // --------------------------------------------------------------------------
  // Divider: stage k settles quotient bit 7-k for all three colors.
  // --------------------------------------------------------------------------
  div_t        dv_nxt [NDIV];
  div_t        dv_src;
  logic [41:0] trial;

  always_comb begin
    for (int k = 0; k < NDIV; k++) begin
      dv_src    = (k == 0) ? div_in : dv_r[(k == 0) ? 0 : k - 1];
      dv_nxt[k] = dv_src;
      trial     = 42'(dv_src.dv) << (NDIV - 1 - k);
      for (int c = 0; c < 3; c++) begin
        if (dv_src.rem[c] >= trial) begin
          dv_nxt[k].rem[c]            = dv_src.rem[c] - trial;
          dv_nxt[k].q[c][NDIV - 1 - k] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NDIV; k++) begin
        dv_r[k] <= '0;
      end
    end else if (adv) begin
      for (int k = 0; k < NDIV; k++) begin
        dv_r[k] <= dv_nxt[k];
      end
    end
  end

  assign out_valid           = dv_r[NDIV-1].rv;
  assign out_transparent_out = dv_r[NDIV-1].tr;
  assign out_red_out         = dv_r[NDIV-1].tr ? 8'd0 : dv_r[NDIV-1].q[0];
  assign out_green_out       = dv_r[NDIV-1].tr ? 8'd0 : dv_r[NDIV-1].q[1];
  assign out_blue_out        = dv_r[NDIV-1].tr ? 8'd0 : dv_r[NDIV-1].q[2];

endmodule
